// ===== hdl/rfa_pkg.sv =====
package rfa_pkg;

	localparam int WORD_W = 32;
	localparam int IDX_W  = 3;
	localparam int MODE_W = 3;
	localparam int CNT_W  = $clog2(WORD_W);

	typedef enum logic [MODE_W-1:0] {
		MODE_CMOV  = 3'd0,
		MODE_ADD   = 3'd1,
		MODE_MUL   = 3'd2,
		MODE_DIV   = 3'd3,
		MODE_NAND  = 3'd4,
		MODE_LOADI = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		SER_ADD = 2'd0,
		SER_MUL = 2'd1,
		SER_DIV = 2'd2
	} ser_op_t;

	typedef struct packed {
		logic    start;
		ser_op_t op;
	} ser_req_t;

endpackage

// ===== hdl/rfa_regfile.sv =====
module rfa_regfile import rfa_pkg::*; #(
	parameter int NUM_REGS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [IDX_W-1:0]  rd_addr0,
	input  logic [IDX_W-1:0]  rd_addr1,
	output logic [WORD_W-1:0] rd_data0,
	output logic [WORD_W-1:0] rd_data1,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_addr,
	input  logic [WORD_W-1:0] wr_data
);

	localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

	logic [WORD_W-1:0]   mem_q [NUM_REGS];
	logic [NUM_REGS-1:0] valid_q;

	logic          ok0, ok1, okw;
	logic [AW-1:0] idx0, idx1, idxw;

	assign ok0  = int'(rd_addr0) < NUM_REGS;
	assign ok1  = int'(rd_addr1) < NUM_REGS;
	assign okw  = int'(wr_addr) < NUM_REGS;
	assign idx0 = AW'(rd_addr0);
	assign idx1 = AW'(rd_addr1);
	assign idxw = AW'(wr_addr);

	// An entry never written since reset reads as zero, as does any index past the file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en && okw) begin
			valid_q[idxw] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && okw) begin
			mem_q[idxw] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data0 <= (ok0 && valid_q[idx0]) ? mem_q[idx0] : '0;
			rd_data1 <= (ok1 && valid_q[idx1]) ? mem_q[idx1] : '0;
		end
	end

endmodule

// ===== hdl/rfa_serial.sv =====
module rfa_serial import rfa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  ser_req_t          req,
	input  logic [WORD_W-1:0] op_b,
	input  logic [WORD_W-1:0] op_c,
	output logic              done,
	output logic [WORD_W-1:0] result
);

	localparam logic [CNT_W-1:0] LAST = CNT_W'(WORD_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	ser_op_t           op_q;
	logic [WORD_W-1:0] w0_q, w1_q, w2_q;
	logic              carry_q;

	logic              sum_bit, carry_nx;
	logic [WORD_W-1:0] mul_sum;
	logic [WORD_W:0]   shifted, diff;
	logic              ge;

	// Add works one bit per cycle; multiply and divide retire one multiplier
	// or quotient bit per cycle.
	assign sum_bit  = w0_q[0] ^ w1_q[0] ^ carry_q;
	assign carry_nx = (w0_q[0] & w1_q[0]) | (carry_q & (w0_q[0] ^ w1_q[0]));
	assign mul_sum  = w0_q + w1_q;
	assign shifted  = {w0_q, w1_q[WORD_W-1]};
	assign diff     = shifted - {1'b0, w2_q};
	assign ge       = ~diff[WORD_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q    <= req.op;
			carry_q <= 1'b0;
			case (req.op)
				SER_ADD: begin
					w0_q <= op_b;
					w1_q <= op_c;
					w2_q <= op_c;
				end
				SER_MUL, SER_DIV: begin
					w0_q <= '0;
					w1_q <= op_b;
					w2_q <= op_c;
				end
				default: begin
					w0_q <= op_b;
					w1_q <= op_c;
					w2_q <= op_c;
				end
			endcase
		end else if (busy_q) begin
			case (op_q)
				SER_ADD: begin
					w0_q    <= {sum_bit, w0_q[WORD_W-1:1]};
					w1_q    <= {1'b0, w1_q[WORD_W-1:1]};
					carry_q <= carry_nx;
				end
				SER_MUL: begin
					if (w2_q[0]) begin
						w0_q <= mul_sum;
					end
					w1_q <= {w1_q[WORD_W-2:0], 1'b0};
					w2_q <= {1'b0, w2_q[WORD_W-1:1]};
				end
				SER_DIV: begin
					w0_q <= ge ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
					w1_q <= {w1_q[WORD_W-2:0], ge};
				end
				default: begin
					w0_q <= w0_q;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = (op_q == SER_DIV) ? w1_q : w0_q;

endmodule

// ===== hdl/register_file_alu.sv =====
// Sequence: the result is offered after the EXEC, READA and OUT states for cmov, nand,
// load immediate, divide by zero and unused modes; add, multiply and divide by a nonzero
// value also wait in SERIAL for the 32-step bit-serial unit.
// Flow: one item at a time; the next item is taken while a finished result still
// waits at the output register.
// Reset: arst_n clears control state and marks every register of the file as zero.
module register_file_alu import rfa_pkg::*; #(
	parameter int NUM_REGS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [MODE_W-1:0] mode,
	input  logic [IDX_W-1:0]  dest_index,
	input  logic [IDX_W-1:0]  src_b_index,
	input  logic [IDX_W-1:0]  src_c_index,
	input  logic [WORD_W-1:0] immediate,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [WORD_W-1:0] dest_value,
	output logic              written,
	output logic              divide_by_zero
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_EXEC   = 5'b00010,
		S_SERIAL = 5'b00100,
		S_READA  = 5'b01000,
		S_OUT    = 5'b10000
	} state_t;

	state_t            state_q;
	mode_t             mode_q;
	logic [IDX_W-1:0]  dest_q;
	logic [WORD_W-1:0] imm_q;
	logic              wr_flag_q;
	logic              dz_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] out_value_q;
	logic              out_written_q;
	logic              out_dz_q;

	logic              accept;
	logic              dest_ok;
	logic              out_free;
	logic [WORD_W-1:0] b_val, c_val;
	logic [WORD_W-1:0] exe_val;
	logic              exe_wr, exe_dz, ser_go;
	ser_req_t          ser_req;
	logic              ser_done;
	logic [WORD_W-1:0] ser_result;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr0;
	logic              wr_en;
	logic [WORD_W-1:0] wr_data;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign dest_ok  = int'(dest_q) < NUM_REGS;
	assign out_free = !out_valid_q || !out_stall;

	// Port 0 reads B at the input transfer and reads A back after the write.
	assign rd_en    = accept || (state_q == S_READA);
	assign rd_addr0 = (state_q == S_READA) ? dest_q : src_b_index;

	rfa_regfile #(
		.NUM_REGS(NUM_REGS)
	) u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr0 (rd_addr0),
		.rd_addr1 (src_c_index),
		.rd_data0 (b_val),
		.rd_data1 (c_val),
		.wr_en    (wr_en),
		.wr_addr  (dest_q),
		.wr_data  (wr_data)
	);

	always_comb begin
		exe_val    = '0;
		exe_wr     = 1'b0;
		exe_dz     = 1'b0;
		ser_go     = 1'b0;
		ser_req.op = SER_ADD;
		case (mode_q)
			MODE_CMOV: begin
				exe_val = b_val;
				exe_wr  = (c_val != '0);
			end
			MODE_ADD: begin
				ser_go     = 1'b1;
				ser_req.op = SER_ADD;
			end
			MODE_MUL: begin
				ser_go     = 1'b1;
				ser_req.op = SER_MUL;
			end
			MODE_DIV: begin
				if (c_val == '0) begin
					exe_dz = 1'b1;
				end else begin
					ser_go     = 1'b1;
					ser_req.op = SER_DIV;
				end
			end
			MODE_NAND: begin
				exe_val = ~(b_val & c_val);
				exe_wr  = 1'b1;
			end
			MODE_LOADI: begin
				exe_val = imm_q;
				exe_wr  = 1'b1;
			end
			default: begin
				exe_wr = 1'b0;
			end
		endcase
		ser_req.start = (state_q == S_EXEC) && ser_go;
	end

	rfa_serial u_serial (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ser_req),
		.op_b   (b_val),
		.op_c   (c_val),
		.done   (ser_done),
		.result (ser_result)
	);

	assign wr_en   = ((state_q == S_EXEC) && exe_wr) || ((state_q == S_SERIAL) && ser_done);
	assign wr_data = (state_q == S_SERIAL) ? ser_result : exe_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= ser_go ? S_SERIAL : S_READA;
				end
				S_SERIAL: begin
					if (ser_done) begin
						state_q <= S_READA;
					end
				end
				S_READA: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode_t'(mode);
			dest_q <= dest_index;
			imm_q  <= immediate;
		end
		if (state_q == S_EXEC) begin
			wr_flag_q <= (exe_wr || ser_go) && dest_ok;
			dz_q      <= exe_dz;
		end
		if ((state_q == S_OUT) && out_free) begin
			out_value_q   <= b_val;
			out_written_q <= wr_flag_q;
			out_dz_q      <= dz_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign dest_value     = out_value_q;
	assign written        = out_written_q;
	assign divide_by_zero = out_dz_q;

`ifndef SYNTHESIS
	a_dz_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_dz_q && out_written_q))
		else $error("divide by zero reported together with a register write");

	a_write_then_readback: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (state_q == S_READA))
		else $error("register write not followed by read-back of A");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result presented outside of output state");

	a_serial_done_in_serial: assert property (@(posedge clk) disable iff (!arst_n)
		ser_done |-> (state_q == S_SERIAL))
		else $error("serial unit finished while controller not waiting");
`endif

endmodule
